// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the round-robin multi-queue block.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RRMF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRMF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RRMF_ASSERT(label, clk, rst_n, prop, msg)
`define RRMF_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/rrmf_pkg.sv =====
// Shared constants, codes and payload types of the round-robin multi-queue block.
// No dependencies; the core, front, engine and result-queue files import this package.
package rrmf_pkg;

	localparam int NUM_PRODUCERS = 8;
	localparam int QUEUE_DEPTH   = 16;
	localparam int DATA_WIDTH    = 32;

	// fixed field widths of the ports
	localparam int CFG_W    = 4;
	localparam int PID_IN_W = 4;
	localparam int ITEM_W   = 32;
	localparam int COUNT_W  = 8;

	localparam int PID_W     = (NUM_PRODUCERS > 1) ? $clog2(NUM_PRODUCERS) : 1;
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W    = PID_W + PTR_W;
	localparam int RAM_DEPTH = 2 ** ADDR_W;
	localparam int TOTAL_MAX = NUM_PRODUCERS * QUEUE_DEPTH;

	localparam int IN_Q_DEPTH  = 2;
	localparam int IN_Q_PTR_W  = $clog2(IN_Q_DEPTH);
	localparam int IN_Q_CNT_W  = $clog2(IN_Q_DEPTH + 1);
	localparam int OUT_Q_DEPTH = 4;
	localparam int OUT_Q_PTR_W = $clog2(OUT_Q_DEPTH);
	localparam int OUT_Q_CNT_W = $clog2(OUT_Q_DEPTH + 1);

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BAD_ID = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		op_t                 operation;
		logic [PID_IN_W-1:0] producer_id;
		logic [ITEM_W-1:0]   item_in;
	} rrmf_in_t;

	typedef struct packed {
		status_t            status;
		logic [ITEM_W-1:0]  item_out;
		logic [COUNT_W-1:0] total_count;
		logic               all_empty;
	} rrmf_out_t;

	// classified request handed from the front to the engine
	typedef struct packed {
		op_t                   op;
		logic                  bad_id;
		logic [PID_W-1:0]      pid;
		logic [DATA_WIDTH-1:0] data;
	} rrmf_req_t;

endpackage

// ===== rtl/round_robin_multi_fifo_core.sv =====
// Round-robin multi-queue arbiter. Eight producer queues of sixteen 32-bit words each share
// one word store. A request either enqueues a word into a named queue or dequeues the oldest
// word of the next non-empty active queue in round-robin order; each request yields exactly
// one result with a status, the popped word, the total words held and an all-empty flag.
// Requests enter through a two-deep input queue, an engine executes one request per clock while
// the result queue has a slot, and results leave through a four-deep result queue, so the block
// sustains one request per cycle when the consumer keeps popping. Once the input queue holds a
// request, the engine takes it and registers the word store read, and the result is then
// written into the result queue, where it shows as empty going low. The throughput limit is
// the engine: one update of the per-queue heads and fills and one store access per clock. The
// producer index is checked only for an enqueue; a dequeue ignores it. The active_producers
// register (cfg_data, 1..8, a 0 reads as 1, larger values as 8) may only be written while no
// request is in flight; a write empties every queue and resets the round-robin pointer.
// cfg_ready is always high. Depends on rrmf_pkg, rrmf_front, rrmf_back, rrmf_out_q and
// assert_macros.svh.
`include "assert_macros.svh"

module round_robin_multi_fifo_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  rrmf_pkg::rrmf_in_t         request,
	output logic                       empty,
	input  logic                       pop,
	output rrmf_pkg::rrmf_out_t        result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rrmf_pkg::CFG_W-1:0] cfg_data
);
	import rrmf_pkg::*;

	logic [CFG_W-1:0] active_q;
	logic [CFG_W-1:0] cfg_clamped;
	logic             cfg_write;

	logic      req_valid;
	logic      req_ready;
	rrmf_req_t req;
	logic      res_valid;
	rrmf_out_t res;
	logic      out_space;

	// configuration: always ready, clamped into 1..NUM_PRODUCERS
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_comb begin
		priority if (cfg_data == '0) begin
			cfg_clamped = CFG_W'(1);
		end else if (cfg_data > CFG_W'(NUM_PRODUCERS)) begin
			cfg_clamped = CFG_W'(NUM_PRODUCERS);
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CFG_W'(NUM_PRODUCERS);
		end else if (cfg_write) begin
			active_q <= cfg_clamped;
		end
	end

	// front: index check and input queue
	rrmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.active    (active_q),
		.push      (push),
		.full      (full),
		.request   (request),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	// engine: issues only when the result queue has a slot for it
	rrmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.active    (active_q),
		.clear     (cfg_write),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.out_space (out_space),
		.res_valid (res_valid),
		.res       (res)
	);

	// result queue toward the consumer
	rrmf_out_q u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.space  (out_space),
		.empty  (empty),
		.pop    (pop),
		.dout   (result)
	);

	// the reported total can never exceed the storage of all queues
	`RRMF_ASSERT(a_total_bound, clk, arst_n, !empty |-> (result.total_count <= COUNT_W'(TOTAL_MAX)), "total count above capacity")
	// all_empty must agree with the reported total
	`RRMF_ASSERT(a_empty_flag, clk, arst_n, !empty |-> (result.all_empty == (result.total_count == '0)), "all_empty disagrees with total")
	// only a successful dequeue carries a word
	`RRMF_ASSERT_NEVER(a_item_zero, clk, arst_n, !empty && result.status != ST_OK && result.item_out != '0, "word on a failed request")
	// a configuration write always leaves a legal producer count
	`RRMF_ASSERT(a_cfg_clamp, clk, arst_n, cfg_write |=> (active_q >= CFG_W'(1) && active_q <= CFG_W'(NUM_PRODUCERS)), "producer count out of range")

endmodule

// ===== rtl/rrmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module rrmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rrmf_front.sv =====
// Front end: checks the producer index of each enqueue and holds every request in a short queue.
// Depends on rrmf_pkg.
module rrmf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [rrmf_pkg::CFG_W-1:0] active,
	input  logic                     push,
	output logic                     full,
	input  rrmf_pkg::rrmf_in_t       request,
	output logic                     req_valid,
	input  logic                     req_ready,
	output rrmf_pkg::rrmf_req_t      req
);
	import rrmf_pkg::*;

	rrmf_req_t             entry_q [IN_Q_DEPTH];
	logic [IN_Q_PTR_W-1:0] wr_ptr_q;
	logic [IN_Q_PTR_W-1:0] rd_ptr_q;
	logic [IN_Q_CNT_W-1:0] count_q;
	rrmf_req_t             classified;
	logic                  do_push;
	logic                  do_pop;

	// the index only matters for an enqueue; a dequeue ignores it
	always_comb begin
		classified.op     = request.operation;
		classified.bad_id = (request.operation == OP_ENQ) && (request.producer_id >= active);
		classified.pid    = request.producer_id[PID_W-1:0];
		classified.data   = request.item_in[DATA_WIDTH-1:0];
	end

	assign full      = (count_q == IN_Q_CNT_W'(IN_Q_DEPTH));
	assign req_valid = (count_q != '0);
	assign req       = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = req_valid && req_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/rrmf_back.sv =====
// Queue engine: per-queue heads and fills, round-robin pick, word storage, result stage.
// Depends on rrmf_pkg and rrmf_ram.
module rrmf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rrmf_pkg::CFG_W-1:0] active,
	input  logic                       clear,
	input  logic                       req_valid,
	input  rrmf_pkg::rrmf_req_t        req,
	output logic                       req_ready,
	input  logic                       out_space,
	output logic                       res_valid,
	output rrmf_pkg::rrmf_out_t        res
);
	import rrmf_pkg::*;

	logic [PTR_W-1:0]   heads_q [NUM_PRODUCERS];
	logic [FILL_W-1:0]  fill_q  [NUM_PRODUCERS];
	logic [PID_W-1:0]   next_q;
	logic [COUNT_W-1:0] total_q;

	logic               valid_s2;
	status_t            status_s2;
	logic               pop_s2;
	logic [COUNT_W-1:0] total_s2;

	logic                  fire;
	logic                  found;
	logic [PID_W-1:0]      pick;
	logic                  q_full;
	logic [PTR_W:0]        tail_sum;
	logic [PTR_W-1:0]      tail;
	logic [CFG_W:0]        next_sum;
	logic [PID_W-1:0]      next_start;
	logic [PTR_W-1:0]      head_inc;
	status_t               status;
	logic                  enq_ok;
	logic                  deq_ok;
	logic [COUNT_W-1:0]    total_next;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign req_ready = out_space;
	assign fire      = req_valid && out_space;

	// rotating-priority pick over non-empty queues, starting at next_q;
	// inactive queues are always empty, so scanning all of them is safe
	always_comb begin
		logic [PID_W:0] idx;
		found = 1'b0;
		pick  = '0;
		idx   = '0;
		for (int i = 0; i < NUM_PRODUCERS; i++) begin
			idx = {1'b0, next_q} + (PID_W + 1)'(i);
			if (idx >= (PID_W + 1)'(NUM_PRODUCERS)) begin
				idx = idx - (PID_W + 1)'(NUM_PRODUCERS);
			end
			if (!found && fill_q[idx[PID_W-1:0]] != '0) begin
				found = 1'b1;
				pick  = idx[PID_W-1:0];
			end
		end
	end

	assign q_full   = (fill_q[req.pid] == FILL_W'(QUEUE_DEPTH));
	assign tail_sum = (PTR_W + 1)'(heads_q[req.pid]) + (PTR_W + 1)'(fill_q[req.pid]);
	assign tail     = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) ?
		PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : tail_sum[PTR_W-1:0];
	assign head_inc = (heads_q[pick] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : heads_q[pick] + 1'b1;
	assign next_sum   = (CFG_W + 1)'(pick) + 1'b1;
	assign next_start = (next_sum >= {1'b0, active}) ? '0 : PID_W'(next_sum);

	always_comb begin
		priority if (req.bad_id) begin
			status = ST_BAD_ID;
		end else if (req.op == OP_ENQ) begin
			status = q_full ? ST_FULL : ST_OK;
		end else begin
			status = found ? ST_OK : ST_EMPTY;
		end
	end

	assign enq_ok = (status == ST_OK) && (req.op == OP_ENQ);
	assign deq_ok = (status == ST_OK) && (req.op == OP_DEQ);

	always_comb begin
		priority if (enq_ok) begin
			total_next = total_q + 1'b1;
		end else if (deq_ok) begin
			total_next = total_q - 1'b1;
		end else begin
			total_next = total_q;
		end
	end

	assign ram_we    = fire && enq_ok;
	assign ram_waddr = {req.pid, tail};
	assign ram_raddr = {pick, heads_q[pick]};

	rrmf_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (RAM_DEPTH)
	) u_storage (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.data),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PRODUCERS; k++) begin
				heads_q[k] <= '0;
				fill_q[k]  <= '0;
			end
			next_q   <= '0;
			total_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= fire;
			if (clear) begin
				for (int k = 0; k < NUM_PRODUCERS; k++) begin
					heads_q[k] <= '0;
					fill_q[k]  <= '0;
				end
				next_q  <= '0;
				total_q <= '0;
			end else if (fire) begin
				total_q <= total_next;
				if (enq_ok) begin
					fill_q[req.pid] <= fill_q[req.pid] + 1'b1;
				end
				if (deq_ok) begin
					fill_q[pick]  <= fill_q[pick] - 1'b1;
					heads_q[pick] <= head_inc;
					next_q        <= next_start;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status;
			pop_s2    <= deq_ok;
			total_s2  <= total_next;
		end
	end

	assign res_valid       = valid_s2;
	assign res.status      = status_s2;
	assign res.item_out    = pop_s2 ? ITEM_W'(ram_rdata) : '0;
	assign res.total_count = total_s2;
	assign res.all_empty   = (total_s2 == '0);

endmodule

// ===== rtl/rrmf_out_q.sv =====
// Result queue between the engine and the consumer, with a credit check for the engine.
// Depends on rrmf_pkg.
module rrmf_out_q (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rrmf_pkg::rrmf_out_t din,
	output logic                space,
	output logic                empty,
	input  logic                pop,
	output rrmf_pkg::rrmf_out_t dout
);
	import rrmf_pkg::*;

	rrmf_out_t              entry_q [OUT_Q_DEPTH];
	logic [OUT_Q_PTR_W-1:0] wr_ptr_q;
	logic [OUT_Q_PTR_W-1:0] rd_ptr_q;
	logic [OUT_Q_CNT_W-1:0] count_q;
	logic                   do_pop;

	// room for one more result behind the one arriving now
	assign space  = ((OUT_Q_CNT_W + 1)'(count_q) + (OUT_Q_CNT_W + 1)'(push))
		< (OUT_Q_CNT_W + 1)'(OUT_Q_DEPTH);
	assign empty  = (count_q == '0);
	assign dout   = entry_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
